// ===== design/tpi_pkg.sv =====
`default_nettype none

package tpi_pkg;

    localparam int COORD_W = 16;
    localparam int SHADE_W = 16;
    localparam int GAIN_W  = 16;
    localparam int EPS_W   = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // Internal arithmetic widths.
    localparam int DEN_W  = 34;   // |cross product| of two 17-bit differences
    localparam int NUM_W  = 52;   // rounded numerator magnitude
    localparam int QUOT_W = 17;   // quotient, clamped to 2^16
    localparam int GAIN_FRAC = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_PRESSURE_GAIN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEGEN_EPSILON = 1'd1;

    typedef enum logic [1:0] {
        ST_COVERED = 2'd0,
        ST_OUTSIDE = 2'd1,
        ST_DEGEN   = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [COORD_W-1:0] v1_x;
        logic signed [COORD_W-1:0] v1_y;
        logic [SHADE_W-1:0]        v1_shade;
        logic signed [COORD_W-1:0] v2_x;
        logic signed [COORD_W-1:0] v2_y;
        logic [SHADE_W-1:0]        v2_shade;
        logic signed [COORD_W-1:0] v3_x;
        logic signed [COORD_W-1:0] v3_y;
        logic [SHADE_W-1:0]        v3_shade;
        logic signed [COORD_W-1:0] pixel_x;
        logic signed [COORD_W-1:0] pixel_y;
    } t_in_beat;

    typedef struct packed {
        t_status            status;
        logic [SHADE_W-1:0] pixel_shade;
        logic [SHADE_W-1:0] pixel_pressure;
    } t_out_beat;

    // Work handed from the geometry pipe to the divider, and along the divider.
    typedef struct packed {
        t_status            status;
        logic               neg;
        logic [SHADE_W-1:0] c1;
        logic [DEN_W-1:0]   den;
        logic [NUM_W-1:0]   rem;
        logic [QUOT_W-1:0]  quot;
        logic               done;
    } t_div_work;

endpackage

`default_nettype wire

// ===== design/tpi_geom.sv =====
`default_nettype none

module tpi_geom
    import tpi_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic [EPS_W-1:0] i_eps,
    input  wire logic             i_valid,
    input  wire t_in_beat         i_beat,
    output logic                  o_valid,
    output t_div_work             o_work
);

    // Stage 1: coordinate differences.
    logic [6:0] r_v;
    logic signed [16:0] r_d1x, r_d1y, r_d2x, r_d2y, r_wx, r_wy;
    logic signed [16:0] r_ex3, r_ey3, r_qx2, r_qy2, r_qx3, r_qy3;
    logic [SHADE_W-1:0] r1_c1, r1_c2, r1_c3;

    // Stage 2: partial products and Chebyshev lengths.
    logic signed [33:0] r_pdet_a, r_pdet_b, r_psn_a, r_psn_b, r_pun_a, r_pun_b;
    logic signed [33:0] r_pf2_a, r_pf2_b, r_pf3_a, r_pf3_b;
    logic [15:0] r2_m1, r2_m2;
    logic signed [16:0] r2_dc21, r2_dc32;
    logic [SHADE_W-1:0] r2_c1;

    // Stage 3: cross products.
    logic signed [34:0] r_det, r_sn, r_un, r_f2, r_f3;
    logic [15:0] r3_m1, r3_m2;
    logic signed [16:0] r3_dc21, r3_dc32;
    logic [SHADE_W-1:0] r3_c1;

    // Stage 4: magnitudes and the inside test.
    logic [DEN_W-1:0] r_adet, r_aun, r_asn;
    logic r4_inside;
    logic [15:0] r4_m1, r4_m2;
    logic signed [16:0] r4_dc21, r4_dc32;
    logic [SHADE_W-1:0] r4_c1;

    // Stage 5: products for the distance check and the numerator.
    logic [49:0] r_prod_um, r_prod_ea;
    logic signed [NUM_W-1:0] r_pa, r_pb;
    logic r5_deg, r5_inside;
    logic [DEN_W-1:0] r5_aun;
    logic [SHADE_W-1:0] r5_c1;

    // Stage 6: classification and numerator.
    logic signed [NUM_W-1:0] r_num;
    t_status r6_status;
    logic [DEN_W-1:0] r6_aun;
    logic [SHADE_W-1:0] r6_c1;

    // Stage 7: rounded dividend.
    t_div_work r7_work;

    logic [16:0] n_am1x, n_am1y, n_am2x, n_am2y;
    logic signed [34:0] n_det;
    logic [NUM_W-1:0] n_num_u, n_half;

    always_comb begin
        n_am1x = r_d1x[16] ? 17'(-r_d1x) : 17'(r_d1x);
        n_am1y = r_d1y[16] ? 17'(-r_d1y) : 17'(r_d1y);
        n_am2x = r_d2x[16] ? 17'(-r_d2x) : 17'(r_d2x);
        n_am2y = r_d2y[16] ? 17'(-r_d2y) : 17'(r_d2y);
        n_det  = r_det;
        n_num_u = r_num;
        n_half  = NUM_W'(r6_aun[DEN_W-1:1]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[5:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d1x <= 17'(i_beat.pixel_x) - 17'(i_beat.v1_x);
            r_d1y <= 17'(i_beat.pixel_y) - 17'(i_beat.v1_y);
            r_d2x <= 17'(i_beat.v3_x) - 17'(i_beat.v2_x);
            r_d2y <= 17'(i_beat.v3_y) - 17'(i_beat.v2_y);
            r_wx  <= 17'(i_beat.v2_x) - 17'(i_beat.v1_x);
            r_wy  <= 17'(i_beat.v2_y) - 17'(i_beat.v1_y);
            r_ex3 <= 17'(i_beat.v1_x) - 17'(i_beat.v3_x);
            r_ey3 <= 17'(i_beat.v1_y) - 17'(i_beat.v3_y);
            r_qx2 <= 17'(i_beat.pixel_x) - 17'(i_beat.v2_x);
            r_qy2 <= 17'(i_beat.pixel_y) - 17'(i_beat.v2_y);
            r_qx3 <= 17'(i_beat.pixel_x) - 17'(i_beat.v3_x);
            r_qy3 <= 17'(i_beat.pixel_y) - 17'(i_beat.v3_y);
            r1_c1 <= i_beat.v1_shade;
            r1_c2 <= i_beat.v2_shade;
            r1_c3 <= i_beat.v3_shade;

            r_pdet_a <= 34'(r_d1x) * 34'(r_d2y);
            r_pdet_b <= 34'(r_d1y) * 34'(r_d2x);
            r_psn_a  <= 34'(r_wx) * 34'(r_d1y);
            r_psn_b  <= 34'(r_wy) * 34'(r_d1x);
            r_pun_a  <= 34'(r_wx) * 34'(r_d2y);
            r_pun_b  <= 34'(r_wy) * 34'(r_d2x);
            r_pf2_a  <= 34'(r_d2x) * 34'(r_qy2);
            r_pf2_b  <= 34'(r_d2y) * 34'(r_qx2);
            r_pf3_a  <= 34'(r_ex3) * 34'(r_qy3);
            r_pf3_b  <= 34'(r_ey3) * 34'(r_qx3);
            r2_m1    <= (n_am1x > n_am1y) ? n_am1x[15:0] : n_am1y[15:0];
            r2_m2    <= (n_am2x > n_am2y) ? n_am2x[15:0] : n_am2y[15:0];
            r2_dc21  <= $signed({1'b0, r1_c2}) - $signed({1'b0, r1_c1});
            r2_dc32  <= $signed({1'b0, r1_c3}) - $signed({1'b0, r1_c2});
            r2_c1    <= r1_c1;

            r_det   <= 35'(r_pdet_a) - 35'(r_pdet_b);
            r_sn    <= 35'(r_psn_a) - 35'(r_psn_b);
            r_un    <= 35'(r_pun_a) - 35'(r_pun_b);
            r_f2    <= 35'(r_pf2_a) - 35'(r_pf2_b);
            r_f3    <= 35'(r_pf3_a) - 35'(r_pf3_b);
            r3_m1   <= r2_m1;
            r3_m2   <= r2_m2;
            r3_dc21 <= r2_dc21;
            r3_dc32 <= r2_dc32;
            r3_c1   <= r2_c1;

            // Boundary points count as inside: zero is both signs.
            r_adet    <= n_det[34] ? DEN_W'(-n_det) : DEN_W'(n_det);
            r_aun     <= r_un[34] ? DEN_W'(-r_un) : DEN_W'(r_un);
            r_asn     <= r_sn[34] ? DEN_W'(-r_sn) : DEN_W'(r_sn);
            r4_inside <= (!r_sn[34] && !r_f2[34] && !r_f3[34]) ||
                         ((r_sn[34] || r_sn == '0) && (r_f2[34] || r_f2 == '0) &&
                          (r_f3[34] || r_f3 == '0));
            r4_m1   <= r3_m1;
            r4_m2   <= r3_m2;
            r4_dc21 <= r3_dc21;
            r4_dc32 <= r3_dc32;
            r4_c1   <= r3_c1;

            r_prod_um <= 50'(r_aun) * 50'(r4_m1);
            r_prod_ea <= 50'(i_eps) * 50'(r_adet);
            r_pa      <= NUM_W'(r4_dc21) * NUM_W'($signed({1'b0, r_adet}));
            r_pb      <= NUM_W'(r4_dc32) * NUM_W'($signed({1'b0, r_asn}));
            r5_deg    <= (r4_m1 < 16'(i_eps)) || (r4_m2 < 16'(i_eps)) ||
                         (r_adet == '0) || (r_adet < DEN_W'(i_eps)) || (r_aun == '0);
            r5_inside <= r4_inside;
            r5_aun    <= r_aun;
            r5_c1     <= r4_c1;

            r_num <= r_pa + r_pb;
            if (r5_deg || (r_prod_um < r_prod_ea)) begin
                r6_status <= ST_DEGEN;
            end else if (r5_inside) begin
                r6_status <= ST_COVERED;
            end else begin
                r6_status <= ST_OUTSIDE;
            end
            r6_aun <= r5_aun;
            r6_c1  <= r5_c1;

            // Adding half the divisor to the magnitude rounds ties away from zero.
            r7_work.status <= r6_status;
            r7_work.neg    <= r_num[NUM_W-1];
            r7_work.c1     <= r6_c1;
            r7_work.den    <= r6_aun;
            r7_work.rem    <= r_num[NUM_W-1] ? (n_half - n_num_u) : (n_num_u + n_half);
            r7_work.quot   <= '0;
            r7_work.done   <= 1'b0;
        end
    end

    assign o_valid = r_v[6];
    assign o_work  = r7_work;

endmodule

`default_nettype wire

// ===== design/tpi_div.sv =====
`default_nettype none

module tpi_div
    import tpi_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_en,
    input  wire logic  i_valid,
    input  wire t_div_work i_work,
    output logic       o_valid,
    output t_div_work  o_work
);

    localparam int STAGES = QUOT_W + 1;

    logic      r_v    [STAGES];
    t_div_work r_work [STAGES];
    t_div_work n_work [STAGES];
    logic [NUM_W-1:0] n_trial;

    // Front stage: a quotient of 2^17 or more saturates the shade either way,
    // so it is clamped to 2^16 and the bit stages pass it through.
    // Each later stage does one restoring step, most significant quotient bit first.
    always_comb begin
        n_work[0] = i_work;
        if (i_work.rem >= (NUM_W'(i_work.den) << QUOT_W)) begin
            n_work[0].quot = QUOT_W'(1) << (QUOT_W - 1);
            n_work[0].done = 1'b1;
        end
        n_trial = '0;
        for (int j = 1; j < STAGES; j++) begin
            n_work[j] = r_work[j-1];
            n_trial   = NUM_W'(r_work[j-1].den) << (QUOT_W - j);
            if (!r_work[j-1].done && (r_work[j-1].rem >= n_trial)) begin
                n_work[j].rem            = r_work[j-1].rem - n_trial;
                n_work[j].quot[QUOT_W-j] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < STAGES; j++) begin
                r_v[j] <= 1'b0;
            end
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int j = 1; j < STAGES; j++) begin
                r_v[j] <= r_v[j-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < STAGES; j++) begin
                r_work[j] <= n_work[j];
            end
        end
    end

    assign o_valid = r_v[STAGES-1];
    assign o_work  = r_work[STAGES-1];

endmodule

`default_nettype wire

// ===== design/tpi_shade.sv =====
`default_nettype none

module tpi_shade
    import tpi_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic [GAIN_W-1:0] i_gain,
    input  wire logic              i_valid,
    input  wire t_div_work         i_work,
    output logic                   o_valid,
    output t_out_beat              o_beat
);

    logic [2:0] r_v;
    logic [SHADE_W-1:0] r1_shade, r2_shade;
    t_status r1_status, r2_status;
    logic [SHADE_W+GAIN_W-1:0] r2_prod;
    t_out_beat r_out;

    logic signed [18:0] n_sum;
    logic [SHADE_W+GAIN_W-1:0] n_round;

    always_comb begin
        n_sum = i_work.neg ? (19'(i_work.c1) - 19'(i_work.quot))
                           : (19'(i_work.c1) + 19'(i_work.quot));
        n_round = r2_prod + (SHADE_W+GAIN_W)'(1 << (GAIN_FRAC - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_status <= i_work.status;
            if (i_work.status != ST_COVERED || n_sum[18]) begin
                r1_shade <= '0;
            end else if (n_sum > 19'sd65535) begin
                r1_shade <= '1;
            end else begin
                r1_shade <= n_sum[15:0];
            end

            r2_status <= r1_status;
            r2_shade  <= r1_shade;
            r2_prod   <= (SHADE_W+GAIN_W)'(r1_shade) * (SHADE_W+GAIN_W)'(i_gain);

            r_out.status      <= r2_status;
            r_out.pixel_shade <= r2_shade;
            if (n_round[SHADE_W+GAIN_W-1:GAIN_FRAC] > (SHADE_W+GAIN_W-GAIN_FRAC)'(16'hFFFF)) begin
                r_out.pixel_pressure <= '1;
            end else begin
                r_out.pixel_pressure <= n_round[GAIN_FRAC+SHADE_W-1:GAIN_FRAC];
            end
        end
    end

    assign o_valid = r_v[2];
    assign o_beat  = r_out;

endmodule

`default_nettype wire

// ===== design/triangle_pixel_interpolator.sv =====
// Throughput: one beat per cycle, sustained, while the output is not stalled.
// The divider has 18 stages: a clamping front stage, then one quotient bit per stage.
// Reset (synchronous, active low) empties the pipeline and loads the
// registers with pressure gain 0 and degenerate epsilon 1.
`default_nettype none

module triangle_pixel_interpolator
    import tpi_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire t_in_beat              i_in_beat,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output t_out_beat                  o_out_beat,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    // The whole pipeline moves as one. It halts only when the output
    // register holds a beat that the receiver is stalling; bubbles flow
    // through freely otherwise, so a new beat can enter every cycle.
    logic w_en;

    logic [GAIN_W-1:0] r_gain;
    logic [EPS_W-1:0]  r_eps;

    logic      w_geom_valid, w_div_valid;
    t_div_work w_geom_work,  w_div_work;

    assign w_en        = !(o_out_valid && i_out_stall);
    assign o_in_stall  = !w_en;
    assign o_cfg_ready = 1'b1;

    // Configuration registers. The user must write them only while the pipe is idle; the block does not enforce this.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= '0;
            r_eps  <= EPS_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_PRESSURE_GAIN: r_gain <= i_cfg_data[GAIN_W-1:0];
                CFG_DEGEN_EPSILON: r_eps  <= i_cfg_data[EPS_W-1:0];
                default: ;
            endcase
        end
    end

    // Geometry: differences, cross products, degenerate and inside tests,
    // and the rounded dividend for the shade interpolation.
    tpi_geom u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_eps   (r_eps),
        .i_valid (i_in_valid && !o_in_stall),
        .i_beat  (i_in_beat),
        .o_valid (w_geom_valid),
        .o_work  (w_geom_work)
    );

    // Pipelined restoring divider with a clamped quotient.
    tpi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_geom_valid),
        .i_work  (w_geom_work),
        .o_valid (w_div_valid),
        .o_work  (w_div_work)
    );

    // Shade saturation, pressure gain and the output register.
    tpi_shade u_shade (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_gain  (r_gain),
        .i_valid (w_div_valid),
        .i_work  (w_div_work),
        .o_valid (o_out_valid),
        .o_beat  (o_out_beat)
    );

endmodule

`default_nettype wire

// ===== design/tpi_checker.sv =====
`default_nettype none

module tpi_checker
    import tpi_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      o_in_stall,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_beat o_out_beat
);

    a_zero_unless_covered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_beat.status != ST_COVERED) |->
            (o_out_beat.pixel_shade == '0 && o_out_beat.pixel_pressure == '0))
        else $error("uncovered pixel carries a shade or pressure");

    a_stall_follows_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall == (o_out_valid && i_out_stall))
        else $error("input stall does not follow the held output beat");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_beat)))
        else $error("stalled result beat changed");

endmodule

bind triangle_pixel_interpolator tpi_checker u_tpi_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_beat  (o_out_beat)
);

`default_nettype wire
